// ----- rtl/formatted_text_scanner_unit_assert.svh -----
// Assertion macros shared by the formatted text scanner RTL.
// Needs nothing else; the macros expand to nothing when SYNTHESIS is defined.
`ifndef FORMATTED_TEXT_SCANNER_UNIT_ASSERT_SVH
`define FORMATTED_TEXT_SCANNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FTS_ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fts: invariant violated");
`define FTS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fts: implication violated");
`define FTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fts: next-cycle check violated");
`else
`define FTS_ASSERT_HOLDS(label, clk, rst, expr)
`define FTS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/fts_pkg.sv -----
// Shared types, codes and helper functions of the formatted text scanner.
// Used by fts_step, fts_queue and formatted_text_scanner_unit.
package fts_pkg;

  localparam int MAX_DIRECTIVES = 8;
  localparam int SLOT_BITS      = 3;
  localparam int COUNT_BITS     = 4;
  localparam int VALUE_BITS     = 32;
  localparam int CODE_BITS      = 2 * MAX_DIRECTIVES;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = 2;
  localparam int QCNT_BITS      = 3;

  // Input actions.
  localparam logic [1:0] ACT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_EOI   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Conversion codes of the format list.
  localparam logic [1:0] CONV_INT  = 2'd0;
  localparam logic [1:0] CONV_WORD = 2'd1;
  localparam logic [1:0] CONV_CHAR = 2'd2;
  localparam logic [1:0] CONV_NONE = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_INT       = 3'd0;
  localparam logic [2:0] KIND_WORD_CHAR = 3'd1;
  localparam logic [2:0] KIND_WORD_END  = 3'd2;
  localparam logic [2:0] KIND_CHAR      = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_INT_WS   = 7'b0000010,
    PH_INT_SIGN = 7'b0000100,
    PH_INT_DIG  = 7'b0001000,
    PH_WORD_WS  = 7'b0010000,
    PH_WORD_RUN = 7'b0100000,
    PH_CHAR_WS  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [VALUE_BITS-1:0] int_value;
    logic [7:0]            char_value;
    logic [SLOT_BITS-1:0]  slot;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } result_t;

  typedef struct packed {
    phase_t                phase;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] acc;
    logic                  neg;
    logic [COUNT_BITS-1:0] done;
  } scan_state_t;

  // Up to two results per input transaction, always in order.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } step_out_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

endpackage

// ----- rtl/fts_step.sv -----
// Next-state and result logic for one input transaction of the scanner.
// Purely combinational; depends on fts_pkg.
module fts_step
  import fts_pkg::*;
(
  input  logic [CODE_BITS-1:0]  format_codes,
  input  logic [COUNT_BITS-1:0] directive_count,
  input  scan_state_t           state,
  input  logic [1:0]            action,
  input  logic [7:0]            char_code,
  output scan_state_t           state_next,
  output step_out_t             step
);

  logic [COUNT_BITS-1:0] usable;
  logic [COUNT_BITS-1:0] enter_start;
  logic                  found;
  logic [SLOT_BITS-1:0]  found_slot;
  logic [1:0]            found_code;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] acc_times_ten;
  logic                  do_enter;
  logic                  emit_a;
  logic                  emit_fin;
  result_t               res_a;
  result_t               res_fin;

  assign usable = (directive_count > COUNT_BITS'(MAX_DIRECTIVES)) ?
                  COUNT_BITS'(MAX_DIRECTIVES) : directive_count;
  assign enter_start = (action == ACT_START) ? '0 :
                       ({1'b0, state.slot} + COUNT_BITS'(1));
  assign digit = 4'(char_code - 8'd48);
  assign acc_times_ten = (state.acc << 3) + (state.acc << 1);

  // First usable slot at or after the start slot.
  always_comb begin
    found      = 1'b0;
    found_slot = '0;
    for (int k = 0; k < MAX_DIRECTIVES; k++) begin
      if (!found && (COUNT_BITS'(k) >= enter_start) && (COUNT_BITS'(k) < usable) &&
          (format_codes[2*k +: 2] != CONV_NONE)) begin
        found      = 1'b1;
        found_slot = SLOT_BITS'(k);
      end
    end
  end

  assign found_code = format_codes[{found_slot, 1'b0} +: 2];

  always_comb begin
    state_next = state;
    do_enter   = 1'b0;
    emit_a     = 1'b0;
    emit_fin   = 1'b0;
    res_a      = '0;

    if (action == ACT_START) begin
      state_next.done = '0;
      do_enter        = 1'b1;
    end else if (action == ACT_EOI && state.phase != PH_IDLE) begin
      // A pending integer or word completes before the scan closes.
      if (state.phase == PH_INT_DIG) begin
        state_next.done = state.done + COUNT_BITS'(1);
        emit_a          = 1'b1;
        res_a.kind      = KIND_INT;
        res_a.int_value = state.neg ? (VALUE_BITS'(0) - state.acc) : state.acc;
        res_a.slot      = state.slot;
      end else if (state.phase == PH_WORD_RUN) begin
        state_next.done = state.done + COUNT_BITS'(1);
        emit_a          = 1'b1;
        res_a.kind      = KIND_WORD_END;
        res_a.slot      = state.slot;
      end
      emit_fin = 1'b1;
    end else if (action == ACT_CHAR) begin
      unique case (state.phase)
        PH_IDLE: begin
        end
        PH_INT_WS: begin
          if (is_ws(char_code)) begin
          end else if (char_code == "-" || char_code == "+") begin
            state_next.neg   = (char_code == "-");
            state_next.phase = PH_INT_SIGN;
          end else if (is_dig(char_code)) begin
            state_next.acc   = VALUE_BITS'(digit);
            state_next.phase = PH_INT_DIG;
          end else begin
            emit_fin = 1'b1;
          end
        end
        PH_INT_SIGN: begin
          if (is_dig(char_code)) begin
            state_next.acc   = VALUE_BITS'(digit);
            state_next.phase = PH_INT_DIG;
          end else begin
            emit_fin = 1'b1;
          end
        end
        PH_INT_DIG: begin
          if (is_dig(char_code)) begin
            state_next.acc = acc_times_ten + VALUE_BITS'(digit);
          end else begin
            state_next.done = state.done + COUNT_BITS'(1);
            emit_a          = 1'b1;
            res_a.kind      = KIND_INT;
            res_a.int_value = state.neg ? (VALUE_BITS'(0) - state.acc) : state.acc;
            res_a.slot      = state.slot;
            do_enter        = 1'b1;
          end
        end
        PH_WORD_WS: begin
          if (!is_ws(char_code)) begin
            state_next.phase = PH_WORD_RUN;
            emit_a           = 1'b1;
            res_a.kind       = KIND_WORD_CHAR;
            res_a.char_value = char_code;
            res_a.slot       = state.slot;
          end
        end
        PH_WORD_RUN: begin
          emit_a     = 1'b1;
          res_a.slot = state.slot;
          if (!is_ws(char_code)) begin
            res_a.kind       = KIND_WORD_CHAR;
            res_a.char_value = char_code;
          end else begin
            state_next.done = state.done + COUNT_BITS'(1);
            res_a.kind      = KIND_WORD_END;
            do_enter        = 1'b1;
          end
        end
        PH_CHAR_WS: begin
          if (!is_ws(char_code)) begin
            state_next.done  = state.done + COUNT_BITS'(1);
            emit_a           = 1'b1;
            res_a.kind       = KIND_CHAR;
            res_a.char_value = char_code;
            res_a.slot       = state.slot;
            do_enter         = 1'b1;
          end
        end
        default: begin
          state_next.phase = PH_IDLE;
        end
      endcase
    end

    if (do_enter) begin
      if (found) begin
        state_next.slot = found_slot;
        state_next.acc  = '0;
        state_next.neg  = 1'b0;
        unique case (found_code)
          CONV_INT:  state_next.phase = PH_INT_WS;
          CONV_WORD: state_next.phase = PH_WORD_WS;
          CONV_CHAR: state_next.phase = PH_CHAR_WS;
          default:   state_next.phase = PH_IDLE;
        endcase
      end else begin
        emit_fin = 1'b1;
      end
    end

    if (emit_fin) begin
      state_next.phase = PH_IDLE;
    end
  end

  always_comb begin
    res_fin       = '0;
    res_fin.kind  = KIND_DONE;
    res_fin.count = state_next.done;
    res_fin.last  = 1'b1;
  end

  always_comb begin
    step.push0       = emit_a || emit_fin;
    step.push1       = emit_a && emit_fin;
    step.res0        = emit_a ? res_a : res_fin;
    step.res0.count  = state_next.done;
    step.res1        = res_fin;
  end

endmodule

// ----- rtl/fts_queue.sv -----
// Four-entry result queue that takes up to two results per cycle.
// Depends on fts_pkg for the result type and the queue sizes.
module fts_queue
  import fts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push0,
  input  logic                 push1,
  input  result_t              res0,
  input  result_t              res1,
  input  logic                 pop,
  output result_t              head,
  output logic [QCNT_BITS-1:0] count
);

  result_t               entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QPTR_BITS-1:0]  wr_ptr_next;
  logic [QCNT_BITS-1:0]  count_next;

  always_comb begin
    wr_ptr_next = wr_ptr + QPTR_BITS'(push0) + QPTR_BITS'(push1);
    count_next  = count + QCNT_BITS'(push0) + QCNT_BITS'(push1) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
    end
  end

  // The second result of a transaction only ever comes with the first.
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= res0;
    end
    if (push1) begin
      entries[wr_ptr + QPTR_BITS'(1)] <= res1;
    end
  end

  assign head = entries[rd_ptr];

endmodule

// ----- rtl/formatted_text_scanner_unit.sv -----
// Formatted text scanner top level: configuration, scan state and result queue.
// Depends on fts_pkg, fts_step, fts_queue and formatted_text_scanner_unit_assert.svh.
//
//   Channel   Handshake              Payload
//   config    cfg_we                 cfg_index, cfg_data
//   input     in_valid / in_stall    action, char_code
//   output    out_valid / out_stall  result_kind, int_value, char_value,
//                                    directive_slot, matched_count, last
//
// One input transaction is taken per cycle while in_stall is low; its zero to two
// results enter the four-entry queue at the same edge and can leave it from the
// next cycle on. The queue drains one result per cycle while out_stall is low, so
// the input rate equals the output rate when each character yields at most one
// result. in_stall is high while fewer than two queue entries are free.
// Synchronous reset clears configuration, scan state and the queue; no clearing pass.
`include "formatted_text_scanner_unit_assert.svh"
module formatted_text_scanner_unit
  import fts_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [CODE_BITS-1:0]         cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [7:0]                   char_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   result_kind,
  output logic signed [VALUE_BITS-1:0] int_value,
  output logic [7:0]                   char_value,
  output logic [SLOT_BITS-1:0]         directive_slot,
  output logic [COUNT_BITS-1:0]        matched_count,
  output logic                         last
);

  logic [CODE_BITS-1:0]  format_codes;
  logic [COUNT_BITS-1:0] directive_count;
  scan_state_t           state;
  scan_state_t           state_next;
  step_out_t             step;
  result_t               head;
  logic [QCNT_BITS-1:0]  q_count;
  logic                  in_acc;
  logic                  out_acc;
  logic                  fin_taken;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_codes    <= '0;
      directive_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: format_codes    <= cfg_data;
        CFG_COUNT:  directive_count <= cfg_data[COUNT_BITS-1:0];
        default:    format_codes    <= format_codes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_IDLE;
      state.slot  <= '0;
      state.acc   <= '0;
      state.neg   <= 1'b0;
      state.done  <= '0;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  fts_step u_step (
    .format_codes    (format_codes),
    .directive_count (directive_count),
    .state           (state),
    .action          (action),
    .char_code       (char_code),
    .state_next      (state_next),
    .step            (step)
  );

  fts_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push0 (in_acc && step.push0),
    .push1 (in_acc && step.push1),
    .res0  (step.res0),
    .res1  (step.res1),
    .pop   (out_acc),
    .head  (head),
    .count (q_count)
  );

  assign in_stall       = (q_count >= QCNT_BITS'(QUEUE_DEPTH - 1));
  assign out_valid      = (q_count != '0);
  assign result_kind    = head.kind;
  assign int_value      = head.int_value;
  assign char_value     = head.char_value;
  assign directive_slot = head.slot;
  assign matched_count  = head.count;
  assign last           = head.last;

  // An accepted transaction that closes the scan.
  assign fin_taken = in_acc && step.push0 && (step.res0.last || step.push1);

  `FTS_ASSERT_HOLDS(a_queue_bound, clk, rst, q_count <= QCNT_BITS'(QUEUE_DEPTH))
  `FTS_ASSERT_IMPLIES(a_second_needs_first, clk, rst, step.push1, step.push0)
  `FTS_ASSERT_IMPLIES(a_last_is_done, clk, rst, out_valid && last, result_kind == KIND_DONE)
  `FTS_ASSERT_NEXT(a_idle_after_last, clk, rst, fin_taken, state.phase == PH_IDLE)

endmodule

// ----- tb/formatted_text_scanner_unit_checker.sv -----
// Checker for the formatted text scanner: tracks register writes, predicts the results
// of every accepted input transaction and compares them with the output channel.
// Depends on fts_pkg for the result, phase and code definitions.
module formatted_text_scanner_unit_checker
  import fts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CODE_BITS-1:0]  cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [7:0]            char_code,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [2:0]            result_kind,
  input  logic [VALUE_BITS-1:0] int_value,
  input  logic [7:0]            char_value,
  input  logic [SLOT_BITS-1:0]  directive_slot,
  input  logic [COUNT_BITS-1:0] matched_count,
  input  logic                  last,
  output int                    fail_count,
  output int                    pending_cnt,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  logic [CODE_BITS-1:0]  fmt_codes;
  logic [3:0]            conv_count;
  phase_t                scan_phase;
  logic [3:0]            cur_slot;
  logic [VALUE_BITS-1:0] acc;
  logic                  neg;
  logic [3:0]            done_cnt;
  result_t               expected_q[$];

  function automatic bit is_blank(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  task automatic queue_result(input logic [2:0] kind, input logic [VALUE_BITS-1:0] ival,
                              input logic [7:0] cval, input logic [3:0] slot,
                              input logic fin);
    result_t r;
    r.kind       = kind;
    r.int_value  = ival;
    r.char_value = cval;
    r.slot       = slot[SLOT_BITS-1:0];
    r.count      = done_cnt;
    r.last       = fin;
    expected_q.push_back(r);
  endtask

  task automatic close_scan();
    scan_phase = PH_IDLE;
    queue_result(KIND_DONE, '0, '0, '0, 1'b1);
  endtask

  // Moves to the first conversion at or after the given slot that is in use, or ends
  // the scan when none is left. A count above the slot total counts as the total.
  task automatic open_slot(input int first);
    int lim;
    logic [1:0] conv;
    lim = (conv_count > MAX_DIRECTIVES) ? MAX_DIRECTIVES : int'(conv_count);
    for (int s = first; s < lim; s++) begin
      conv = fmt_codes[2*s +: 2];
      if (conv != CONV_NONE) begin
        cur_slot = 4'(s);
        acc = '0;
        neg = 1'b0;
        case (conv)
          CONV_INT:  scan_phase = PH_INT_WS;
          CONV_WORD: scan_phase = PH_WORD_WS;
          default:   scan_phase = PH_CHAR_WS;
        endcase
        return;
      end
    end
    cur_slot = 4'((first > lim) ? first : lim);
    close_scan();
  endtask

  // The value wraps at 32 bits and a minus sign negates it in that width.
  task automatic emit_integer();
    logic [VALUE_BITS-1:0] v;
    v = neg ? (~acc + 1'b1) : acc;
    done_cnt++;
    queue_result(KIND_INT, v, '0, cur_slot, 1'b0);
  endtask

  task automatic predict_transaction(input logic [1:0] act, input logic [7:0] c);
    case (act)
      ACT_START: begin
        done_cnt = '0;
        open_slot(0);
      end
      ACT_EOI: begin
        if (scan_phase != PH_IDLE) begin
          if (scan_phase == PH_INT_DIG) begin
            emit_integer();
          end else if (scan_phase == PH_WORD_RUN) begin
            done_cnt++;
            queue_result(KIND_WORD_END, '0, '0, cur_slot, 1'b0);
          end
          close_scan();
        end
      end
      ACT_CHAR: begin
        case (scan_phase)
          PH_INT_WS: begin
            if (!is_blank(c)) begin
              if (c == CH_MINUS || c == CH_PLUS) begin
                neg = (c == CH_MINUS);
                scan_phase = PH_INT_SIGN;
              end else if (is_numeral(c)) begin
                acc = VALUE_BITS'(c - CH_ZERO);
                scan_phase = PH_INT_DIG;
              end else begin
                close_scan();
              end
            end
          end
          PH_INT_SIGN: begin
            if (is_numeral(c)) begin
              acc = VALUE_BITS'(c - CH_ZERO);
              scan_phase = PH_INT_DIG;
            end else begin
              close_scan();
            end
          end
          PH_INT_DIG: begin
            if (is_numeral(c)) begin
              acc = acc * 32'd10 + VALUE_BITS'(c - CH_ZERO);
            end else begin
              emit_integer();
              open_slot(cur_slot + 1);
            end
          end
          PH_WORD_WS: begin
            if (!is_blank(c)) begin
              scan_phase = PH_WORD_RUN;
              queue_result(KIND_WORD_CHAR, '0, c, cur_slot, 1'b0);
            end
          end
          PH_WORD_RUN: begin
            if (!is_blank(c)) begin
              queue_result(KIND_WORD_CHAR, '0, c, cur_slot, 1'b0);
            end else begin
              done_cnt++;
              queue_result(KIND_WORD_END, '0, '0, cur_slot, 1'b0);
              open_slot(cur_slot + 1);
            end
          end
          PH_CHAR_WS: begin
            if (!is_blank(c)) begin
              done_cnt++;
              queue_result(KIND_CHAR, '0, c, cur_slot, 1'b0);
              open_slot(cur_slot + 1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d slot %0d", $time,
               result_kind, directive_slot);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    check_field("result_kind", 32'(want.kind), 32'(result_kind));
    check_field("int_value", want.int_value, int_value);
    check_field("char_value", 32'(want.char_value), 32'(char_value));
    check_field("directive_slot", 32'(want.slot), 32'(directive_slot));
    check_field("matched_count", 32'(want.count), 32'(matched_count));
    check_field("last", 32'(want.last), 32'(last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fmt_codes  = '0;
      conv_count = '0;
      scan_phase = PH_IDLE;
      cur_slot   = '0;
      acc        = '0;
      neg        = 1'b0;
      done_cnt   = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_we) begin
        if (cfg_index == CFG_FORMAT) fmt_codes = cfg_data;
        else conv_count = cfg_data[3:0];
      end
      if (in_valid && !in_stall) predict_transaction(action, char_code);
    end
    pending_cnt = expected_q.size();
  end

endmodule

// ----- tb/formatted_text_scanner_unit_tb.sv -----
// Testbench top for formatted_text_scanner_unit: clock, reset, register writes, input
// and output traffic with random idling, and the verdict.
// Depends on fts_pkg, the RTL and formatted_text_scanner_unit_checker.
module formatted_text_scanner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fts_pkg::*;

  localparam int         ITEM_TARGET   = 1550;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         QUIET_LIMIT   = 1000;
  localparam int         SETTLE_CYCLES = 4;
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_FORMAT;
  logic [CODE_BITS-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action = ACT_CHAR;
  logic [7:0]            char_code = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            result_kind;
  logic [VALUE_BITS-1:0] int_value;
  logic [7:0]            char_value;
  logic [SLOT_BITS-1:0]  directive_slot;
  logic [COUNT_BITS-1:0] matched_count;
  logic                  last;

  int fail_count;
  int pending_cnt;
  int results_seen;
  int items_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  bit idle_mode = 1'b1;
  bit hold_req = 1'b0;

  formatted_text_scanner_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .int_value(int_value), .char_value(char_value), .directive_slot(directive_slot),
    .matched_count(matched_count), .last(last)
  );

  formatted_text_scanner_unit_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .int_value(int_value), .char_value(char_value), .directive_slot(directive_slot),
    .matched_count(matched_count), .last(last), .fail_count(fail_count),
    .pending_cnt(pending_cnt), .results_seen(results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Any cycle without a transaction on any channel counts toward the timeout.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("formatted_text_scanner_unit test failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_ws();
    int k;
    k = $urandom_range(8, 13);
    return (k == 8) ? CH_SPACE : 8'(k);
  endfunction

  function automatic logic [7:0] rand_char(input bit allow_ws, input bit allow_digit);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((!allow_ws && (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) ||
               (!allow_digit && c >= CH_ZERO && c <= CH_ZERO + 8'd9));
    return c;
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
    int gap;
    gap = idle_mode ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act != ACT_UNDEFINED) items_sent++;
  endtask

  task automatic write_regs(input logic [CODE_BITS-1:0] codes, input logic [3:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FORMAT;
    cfg_data  <= codes;
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_data  <= {{(CODE_BITS-4){1'b0}}, count};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Closes any scan still open, then waits until every predicted result has come out.
  task automatic settle();
    send_item(ACT_EOI, 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One scan: mostly well-formed text for each conversion in use, with occasional
  // noise, restarts, early end of input, missing digits and cut-off tokens.
  task automatic run_scan(input logic [CODE_BITS-1:0] codes, input logic [3:0] count);
    int used;
    int r;
    int reps;
    logic [1:0] conv;
    bit cut;
    used = (count > 4'd8) ? 8 : int'(count);
    send_item(ACT_START, 8'($urandom_range(0, 255)));
    for (int s = 0; s < used; s++) begin
      conv = codes[2*s +: 2];
      if (conv == CONV_NONE) continue;
      if ($urandom_range(0, 9) == 0) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(ACT_START, 8'($urandom_range(0, 255)));
        s = -1;
        continue;
      end
      if (r < 6) begin
        send_item(ACT_EOI, 8'($urandom_range(0, 255)));
        return;
      end
      if (r < 9 && conv == CONV_INT) begin
        if (r == 8) send_item(ACT_CHAR, CH_MINUS);
        send_item(ACT_CHAR, rand_char(1'b0, 1'b0));
        return;
      end
      cut = (r < 14) && (conv != CONV_CHAR);
      reps = $urandom_range(0, 2);
      repeat (reps) send_item(ACT_CHAR, rand_ws());
      case (conv)
        CONV_INT: begin
          r = $urandom_range(0, 2);
          if (r == 1) send_item(ACT_CHAR, CH_MINUS);
          else if (r == 2) send_item(ACT_CHAR, CH_PLUS);
          // Long digit strings can push the value past 32 bits.
          reps = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
          repeat (reps) send_item(ACT_CHAR, CH_ZERO + 8'($urandom_range(0, 9)));
        end
        CONV_WORD: begin
          reps = $urandom_range(1, 5);
          repeat (reps) send_item(ACT_CHAR, rand_char(1'b0, 1'b1));
        end
        default: send_item(ACT_CHAR, rand_char(1'b0, 1'b1));
      endcase
      if (cut) begin
        send_item(ACT_EOI, 8'($urandom_range(0, 255)));
        return;
      end
      if (conv == CONV_INT) send_item(ACT_CHAR, rand_char(1'b1, 1'b0));
      else if (conv == CONV_WORD) send_item(ACT_CHAR, rand_ws());
    end
  endtask

  // The receiver draws a stall length per result; a pending hold request replaces it
  // with one long stall so that the result queue fills and the input backs up.
  initial begin
    int hold;
    forever begin
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = idle_mode ? $urandom_range(0, 8) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [CODE_BITS-1:0] codes;
    logic [3:0] count;
    int scans;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Idle traffic, an undefined action and an empty format list after reset.
    send_item(ACT_CHAR, 8'h78);
    send_item(ACT_EOI, 8'h00);
    send_item(ACT_UNDEFINED, 8'hA5);
    send_item(ACT_START, 8'h00);
    settle();
    // Oversized count over a list of unused slots.
    write_regs(16'hFFFF, 4'd15);
    send_item(ACT_START, 8'hFF);
    settle();
    // Integer, word, character, unused, integer: overflowing negative value, byte
    // extremes, skipped whitespace, and end of input right after a sign.
    write_regs(16'h00E4, 4'd5);
    send_item(ACT_START, 8'h00);
    send_item(ACT_CHAR, 8'd9);
    send_item(ACT_CHAR, CH_MINUS);
    repeat (10) send_item(ACT_CHAR, CH_ZERO + 8'd9);
    send_item(ACT_CHAR, 8'hFF);
    send_item(ACT_CHAR, 8'h00);
    send_item(ACT_CHAR, CH_SPACE);
    send_item(ACT_CHAR, 8'd13);
    send_item(ACT_CHAR, CH_PLUS);
    send_item(ACT_CHAR, CH_PLUS);
    send_item(ACT_EOI, 8'h00);
    settle();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       codes = '0;
        1:       codes = '1;
        2:       codes = 16'h5555;
        3:       codes = 16'hAAAA;
        default: codes = CODE_BITS'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 7))
        0:       count = 4'd0;
        1:       count = 4'd8;
        2:       count = 4'd15;
        default: count = 4'($urandom_range(1, 8));
      endcase
      idle_mode = ($urandom_range(0, 3) != 0);
      if (settings_used == 8) begin
        codes = 16'h5555;
        count = 4'd8;
        idle_mode = 1'b0;
        hold_req = 1'b1;
      end
      write_regs(codes, count);
      scans = $urandom_range(1, 6);
      repeat (scans) run_scan(codes, count);
      settle();
    end

    $display("Run summary: %0d input transactions under %0d register settings,",
             items_sent, settings_used);
    $display("  %0d results compared, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("formatted_text_scanner_unit test passed");
    end else begin
      $display("formatted_text_scanner_unit test failed");
    end
    $finish;
  end

endmodule
